>>> design/inverse_fourier_time_synthesis_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked check macros used by the asserting file of the block.
// ----------------------------------------------------------------------------
`ifndef INVERSE_FOURIER_TIME_SYNTHESIS_ASSERT_SVH
`define INVERSE_FOURIER_TIME_SYNTHESIS_ASSERT_SVH
`ifndef SYNTH
`define IFTS_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define IFTS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define IFTS_ASSERT(lbl, expr)
`define IFTS_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

>>> design/ifts_pkg.sv
// ----------------------------------------------------------------------------
// ifts_pkg
// Shared types and constants of the inverse Fourier time synthesis block.
// ----------------------------------------------------------------------------
package ifts_pkg;

    typedef struct packed {
        logic [15:0]        sample_index;
        logic [31:0]        angular_freq;
        logic signed [31:0] coef_real;
        logic signed [31:0] coef_imag;
        logic               last_term;
    } item_t;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [1:0] count;
    } fifo_stat_t;

    localparam int CORDIC_STEPS = 24;
    localparam int XY_W = 44;
    localparam int Z_W = 32;
    localparam logic [21:0] INV_TWO_PI_Q24 = 22'd2670177;
    localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
    localparam logic signed [24:0] CORDIC_GAIN_Q24 = 25'sd10188014;

    localparam logic [7:0] REG_TIME_STEP = 8'd0;
    localparam logic [7:0] REG_FREQ_STEP = 8'd1;

    function automatic logic [27:0] atan_turn(input logic [4:0] i);
        logic [27:0] a;
        unique case (i)
            5'd0:    a = 28'd134217728;
            5'd1:    a = 28'd79233352;
            5'd2:    a = 28'd41864727;
            5'd3:    a = 28'd21251189;
            5'd4:    a = 28'd10666832;
            5'd5:    a = 28'd5338616;
            5'd6:    a = 28'd2669960;
            5'd7:    a = 28'd1335061;
            5'd8:    a = 28'd667541;
            5'd9:    a = 28'd333772;
            5'd10:   a = 28'd166886;
            5'd11:   a = 28'd83443;
            5'd12:   a = 28'd41721;
            5'd13:   a = 28'd20861;
            5'd14:   a = 28'd10430;
            5'd15:   a = 28'd5215;
            5'd16:   a = 28'd2608;
            5'd17:   a = 28'd1304;
            5'd18:   a = 28'd652;
            5'd19:   a = 28'd326;
            5'd20:   a = 28'd163;
            5'd21:   a = 28'd81;
            5'd22:   a = 28'd41;
            5'd23:   a = 28'd20;
            default: a = 28'd0;
        endcase
        return a;
    endfunction

endpackage

>>> design/ifts_front.sv
// ----------------------------------------------------------------------------
// ifts_front
// Input side: unpacks stream requests and queues them, two entries deep.
// ----------------------------------------------------------------------------
module ifts_front
    import ifts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,  // sample_index, angular_freq, coef_real, coef_imag
    input  logic         s_tlast,  // last_term
    input  logic         pop,
    output item_t        head,
    output fifo_stat_t   stat
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    item_t      item_in;

    assign item_in.sample_index = s_tdata[15:0];
    assign item_in.angular_freq = s_tdata[47:16];
    assign item_in.coef_real    = s_tdata[79:48];
    assign item_in.coef_imag    = s_tdata[111:80];
    assign item_in.last_term    = s_tlast;

    assign s_tready   = (count_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign head       = mem_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == 2'd0);
    assign stat.full  = (count_reg == 2'd2);
    assign stat.count = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> design/ifts_back.sv
// ----------------------------------------------------------------------------
// ifts_back
// Term engine: phase, iterative CORDIC, accumulate and output scaling.
// ----------------------------------------------------------------------------
module ifts_back
    import ifts_pkg::*;
#(
    parameter int MAX_SAMPLES = 65536,
    parameter int ACC_WIDTH = 48
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  item_t       head,
    input  fifo_stat_t  stat,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // sample_value, out_index
    output logic        m_tuser    // clipped
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_PH1      = 12'b000000000010,
        S_PH2      = 12'b000000000100,
        S_PH3      = 12'b000000001000,
        S_PH4      = 12'b000000010000,
        S_ROT_INIT = 12'b000000100000,
        S_ROT      = 12'b000001000000,
        S_GAIN     = 12'b000010000000,
        S_ACC      = 12'b000100000000,
        S_MAG      = 12'b001000000000,
        S_MUL      = 12'b010000000000,
        S_FIN      = 12'b100000000000
    } state_t;

    localparam logic [16:0] MOD_N = 17'(MAX_SAMPLES);
    localparam logic [63:0] RECIP = 64'((64'd1 << 32) + 64'(MAX_SAMPLES) - 64'd1)
                                    / 64'(MAX_SAMPLES);
    localparam logic signed [ACC_WIDTH:0] ACC_MAX =
        (ACC_WIDTH+1)'((65'sd1 <<< (ACC_WIDTH - 1)) - 65'sd1);
    localparam logic signed [ACC_WIDTH:0] ACC_MIN = -ACC_MAX - 1;

    state_t state_reg, state_next;

    logic [31:0]   time_step_reg, freq_step_reg;
    item_t         item_reg;
    logic [63:0]   p_reg;
    logic [15:0]   nq_reg;
    logic [61:0]   r_reg;
    logic [16:0]   nrem_reg;
    logic [39:0]   u_reg;
    logic [15:0]   n_reg;
    logic [23:0]   phase_reg;
    logic signed [XY_W-1:0] x_reg, y_reg;
    logic signed [Z_W-1:0]  z_reg;
    logic [4:0]    i_reg;
    logic signed [60:0] g_reg;
    logic signed [ACC_WIDTH-1:0] sum_reg;
    logic          clip_reg;
    logic [63:0]   mag_reg;
    logic          neg_reg;
    logic [63:0]   f_reg;
    logic [127:0]  prod_reg;
    logic [1:0]    k_reg;
    logic          out_valid_reg;
    logic [31:0]   out_value_reg;
    logic [15:0]   out_index_reg;
    logic          out_clip_reg;

    logic signed [XY_W-1:0] x0, y0, xr, yr;
    logic signed [Z_W-1:0]  atan_ext;
    logic signed [35:0]     xs;
    logic signed [36:0]     term;
    logic signed [ACC_WIDTH:0] sum_ext;
    logic [31:0]   pa, pb;
    logic [127:0]  pp;
    logic [63:0]   qv;
    logic          sat;
    logic [31:0]   res;
    logic          out_free;
    logic [47:0]   nq_full;
    logic [55:0]   un_prod;

    assign out_free = !out_valid_reg || m_tready;
    assign pop      = (state_reg == S_IDLE) && !stat.empty;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_index_reg, out_value_reg};
    assign m_tuser  = out_clip_reg;

    always_comb
    begin
        x0 = {{4{item_reg.coef_real[31]}}, item_reg.coef_real, 8'd0};
        y0 = {{4{item_reg.coef_imag[31]}}, item_reg.coef_imag, 8'd0};
        unique case (phase_reg[23:22])
            2'd0:    begin xr = x0;  yr = y0;  end
            2'd1:    begin xr = -y0; yr = x0;  end
            2'd2:    begin xr = -x0; yr = -y0; end
            default: begin xr = y0;  yr = -x0; end
        endcase
        atan_ext = Z_W'(atan_turn(i_reg));
        xs       = x_reg[43:8];
        term     = g_reg[60:24];
        sum_ext  = (ACC_WIDTH+1)'(sum_reg) + (ACC_WIDTH+1)'(term);
        pa       = k_reg[0] ? mag_reg[63:32] : mag_reg[31:0];
        pb       = k_reg[1] ? f_reg[63:32] : f_reg[31:0];
        pp       = 128'(pa * pb) << (7'(k_reg[0]) * 7'd32 + 7'(k_reg[1]) * 7'd32);
        nq_full  = 48'(item_reg.sample_index * RECIP[32:0]);
        un_prod  = u_reg * n_reg;
        qv       = prod_reg[115:52];
        sat      = (prod_reg[127:116] != 12'd0);
        if (!neg_reg)
        begin
            if (sat || qv > 64'h7FFFFFFF)
            begin
                sat = 1'b1;
                res = 32'h7FFFFFFF;
            end
            else
            begin
                res = qv[31:0];
            end
        end
        else
        begin
            if (sat || qv > 64'h80000000)
            begin
                sat = 1'b1;
                res = 32'h80000000;
            end
            else
            begin
                res = -qv[31:0];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (!stat.empty) state_next = S_PH1;
            S_PH1:      state_next = S_PH2;
            S_PH2:      state_next = S_PH3;
            S_PH3:      state_next = S_PH4;
            S_PH4:      state_next = S_ROT_INIT;
            S_ROT_INIT: state_next = S_ROT;
            S_ROT:      if (i_reg == 5'(CORDIC_STEPS - 1)) state_next = S_GAIN;
            S_GAIN:     state_next = S_ACC;
            S_ACC:      state_next = item_reg.last_term ? S_MAG : S_IDLE;
            S_MAG:      state_next = S_MUL;
            S_MUL:      if (k_reg == 2'd3) state_next = S_FIN;
            S_FIN:      if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head;
        end
        p_reg    <= item_reg.angular_freq * time_step_reg;
        nq_reg   <= nq_full[47:32];
        r_reg    <= p_reg[63:24] * INV_TWO_PI_Q24;
        nrem_reg <= {1'b0, item_reg.sample_index} - 17'(nq_reg * MOD_N);
        u_reg    <= r_reg[51:12];
        n_reg    <= (nrem_reg >= MOD_N) ? 16'(nrem_reg - MOD_N) : nrem_reg[15:0];
        phase_reg <= un_prod[39:16];
        g_reg    <= xs * CORDIC_GAIN_Q24;
        if (state_reg == S_ROT_INIT)
        begin
            x_reg <= xr;
            y_reg <= yr;
            z_reg <= Z_W'({phase_reg[21:0], 6'd0});
        end
        else if (state_reg == S_ROT)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - (y_reg >>> i_reg);
                y_reg <= y_reg + (x_reg >>> i_reg);
                z_reg <= z_reg - atan_ext;
            end
            else
            begin
                x_reg <= x_reg + (y_reg >>> i_reg);
                y_reg <= y_reg - (x_reg >>> i_reg);
                z_reg <= z_reg + atan_ext;
            end
        end
        if (state_reg == S_MAG)
        begin
            neg_reg  <= sum_reg[ACC_WIDTH-1];
            mag_reg  <= sum_reg[ACC_WIDTH-1] ? 64'(-sum_reg) : 64'(sum_reg);
            f_reg    <= 64'(freq_step_reg * INV_PI_Q32);
            prod_reg <= 128'd0;
        end
        else if (state_reg == S_MUL)
        begin
            prod_reg <= prod_reg + pp;
        end
        if (state_reg == S_FIN && out_free)
        begin
            out_value_reg <= res;
            out_index_reg <= n_reg;
            out_clip_reg  <= sat || clip_reg;
        end
    end

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            time_step_reg <= 32'd0;
            freq_step_reg <= 32'd0;
            sum_reg       <= '0;
            clip_reg      <= 1'b0;
            i_reg         <= 5'd0;
            k_reg         <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                if (cfg_index == REG_TIME_STEP) time_step_reg <= cfg_data;
                if (cfg_index == REG_FREQ_STEP) freq_step_reg <= cfg_data;
            end
            i_reg <= (state_reg == S_ROT) ? i_reg + 5'd1 : 5'd0;
            k_reg <= (state_reg == S_MUL) ? k_reg + 2'd1 : 2'd0;
            if (state_reg == S_ACC)
            begin
                if (sum_ext > ACC_MAX)
                begin
                    sum_reg  <= ACC_MAX[ACC_WIDTH-1:0];
                    clip_reg <= 1'b1;
                end
                else if (sum_ext < ACC_MIN)
                begin
                    sum_reg  <= ACC_MIN[ACC_WIDTH-1:0];
                    clip_reg <= 1'b1;
                end
                else
                begin
                    sum_reg <= sum_ext[ACC_WIDTH-1:0];
                end
            end
            else if (state_reg == S_FIN && out_free)
            begin
                sum_reg  <= '0;
                clip_reg <= 1'b0;
            end
            if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> design/inverse_fourier_time_synthesis.sv
// ----------------------------------------------------------------------------
// inverse_fourier_time_synthesis
// Direct-summation inverse Fourier synthesis of one time sample per run.
// ----------------------------------------------------------------------------
// Each frequency term enters a two-entry input queue; the term engine takes
// one term at a time: phase steps, the 24-iteration CORDIC loop on one shared
// rotator, gain and accumulate, and for a last term the output scaling with
// its four 32x32 partial products and any wait for the output register. The
// queue keeps accepting up to two terms while the engine works and while a
// result waits on the output register. Registers are to be written through
// cfg by the user only at a time the block is idle; the block itself does not
// enforce this. time_step is index 0 and freq_step index 1.
`include "inverse_fourier_time_synthesis_assert.svh"

module inverse_fourier_time_synthesis
    import ifts_pkg::*;
#(
    parameter int MAX_SAMPLES = 65536,
    parameter int ACC_WIDTH = 48
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,  // sample_index, angular_freq, coef_real, coef_imag
    input  logic         s_tlast,  // last_term
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,  // sample_value, out_index
    output logic         m_tuser   // clipped
);

    item_t      head;
    fifo_stat_t stat;
    logic       pop;

    assign cfg_ready = 1'b1;

    ifts_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .pop      (pop),
        .head     (head),
        .stat     (stat)
    );

    ifts_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .ACC_WIDTH   (ACC_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head      (head),
        .stat      (stat),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    `IFTS_ASSERT(a_count_bound, stat.count != 2'd3)
    `IFTS_ASSERT_IMP(a_pop_nonempty, pop, !stat.empty)
    `IFTS_ASSERT_IMP(a_full_blocks, stat.full, !s_tready)

endmodule
